>>> rtl/byte_stream_hash_256_macros.svh
// ----------------------------------------------------------------------------
// byte_stream_hash_256 assertion macros
// Clocked property checks used by the checker file of the hash block.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_HASH_256_MACROS_SVH
`define BYTE_STREAM_HASH_256_MACROS_SVH

// checked on every rising edge while out of reset
`define BSH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bsh256 check failed");

// checked on every rising edge, reset included
`define BSH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bsh256 check failed");

`endif

>>> rtl/bsh256_pkg.sv
// ----------------------------------------------------------------------------
// bsh256_pkg
// Types, constants and helpers of the byte stream hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsh256_pkg;

  localparam logic [63:0] HASH_C1 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_C2 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] HASH_C3 = 64'h94D049BB133111EB;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;

  // only the first four block words reach the chain
  localparam int unsigned USED_BYTES = 32;

  localparam int unsigned ROT_V0   = 7;
  localparam int unsigned ROT_V1   = 13;
  localparam int unsigned ROT_V2   = 23;
  localparam int unsigned ROT_V3   = 37;
  localparam int unsigned ROT_SIG  = 17;
  localparam int unsigned ROT_POST = 31;

  // final mixes after the last block, counted down to zero
  localparam logic [1:0] FINAL_MIXES_M1 = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;
  } out_item_t;

  // one block job for the back end
  typedef struct packed {
    logic                        fin;
    logic                        extra;
    logic [USED_BYTES-1:0][7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int unsigned r);
    return (x >> r) | (x << (64 - r));
  endfunction

endpackage

`default_nettype wire

>>> rtl/bsh256_front.sv
// ----------------------------------------------------------------------------
// bsh256_front
// Takes input beats, packs message bytes and builds block jobs, padding
// included, for the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh256_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  bsh256_pkg::in_item_t  in_item_i,
  output logic                  in_stall_o,
  input  logic                  q_full_i,
  output bsh256_pkg::cmd_beat_t push_o
);
  import bsh256_pkg::*;

  logic [USED_BYTES-1:0][7:0] buf_q, buf_d;
  logic [5:0]                 pos_q, pos_d;
  logic                       accept;
  logic [USED_BYTES-1:0][7:0] pad_data;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // bytes below the fill point, then the pad mark, then zeros
  always_comb begin
    for (int i = 0; i < USED_BYTES; i++) begin
      if (6'(i) < pos_q) begin
        pad_data[i] = buf_q[i];
      end else if (6'(i) == pos_q) begin
        pad_data[i] = PAD_MARK;
      end else begin
        pad_data[i] = 8'h00;
      end
    end
  end

  always_comb begin
    buf_d            = buf_q;
    pos_d            = pos_q;
    push_o.valid     = 1'b0;
    push_o.cmd.fin   = 1'b0;
    push_o.cmd.extra = 1'b0;
    push_o.cmd.data  = buf_q;
    if (accept) begin
      if (in_item_i.mode) begin
        push_o.valid     = 1'b1;
        push_o.cmd.fin   = 1'b1;
        push_o.cmd.extra = (pos_q >= LEN_OFFSET);
        push_o.cmd.data  = pad_data;
        pos_d            = '0;
      end else begin
        if (!pos_q[5]) begin
          buf_d[pos_q[4:0]] = in_item_i.byte_value;
        end
        pos_d        = pos_q + 6'd1;
        push_o.valid = (pos_q == LAST_POS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

`default_nettype wire

>>> rtl/bsh256_queue.sv
// ----------------------------------------------------------------------------
// bsh256_queue
// Short job queue between the packing front end and the mixing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh256_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bsh256_pkg::cmd_beat_t push_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output bsh256_pkg::cmd_beat_t head_o
);
  import bsh256_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bsh256_back.sv
// ----------------------------------------------------------------------------
// bsh256_back
// Mixing sequencer: chain XOR, mix steps, signature update, final mixes
// and the digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsh256_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bsh256_pkg::cmd_beat_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output bsh256_pkg::out_item_t out_item_o,
  input  logic                  out_stall_i
);
  import bsh256_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MIXA = 6'b000010,
    ST_MIXB = 6'b000100,
    ST_MIXC = 6'b001000,
    ST_POST = 6'b010000,
    ST_EMIT = 6'b100000
  } back_state_e;

  back_state_e                state_q, state_d;
  logic [3:0][63:0]           v_q, v_d;
  logic [63:0]                sig_q, sig_d;
  logic [USED_BYTES-1:0][7:0] blk_q, blk_d;
  logic                       fin_q, fin_d;
  logic                       extra_q, extra_d;
  logic                       xor_en_q, xor_en_d;
  logic [1:0]                 mix_left_q, mix_left_d;
  logic                       out_valid_q, out_valid_d;
  out_item_t                  out_q, out_d;
  logic [3:0][63:0]           x;
  logic [63:0]                t3;
  logic                       slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // block words enter the chain only in the first step of a block
  always_comb begin
    for (int w = 0; w < 4; w++) begin
      x[w] = xor_en_q ? (v_q[w] ^ blk_q[w*8 +: 8]) : v_q[w];
    end
  end

  assign t3 = v_q[3] + (v_q[0] ^ HASH_C3);

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    sig_d       = sig_q;
    blk_d       = blk_q;
    fin_d       = fin_q;
    extra_d     = extra_q;
    xor_en_d    = xor_en_q;
    mix_left_d  = mix_left_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          blk_d    = head_i.cmd.data;
          fin_d    = head_i.cmd.fin;
          extra_d  = head_i.cmd.extra;
          xor_en_d = 1'b1;
          state_d  = ST_MIXA;
        end
      end
      ST_MIXA: begin
        v_d[0]  = x[0] + (x[1] ^ sig_q);
        v_d[1]  = x[1] + (x[2] ^ HASH_C1);
        v_d[2]  = x[2] + (x[3] ^ HASH_C2);
        v_d[3]  = x[3];
        state_d = ST_MIXB;
      end
      ST_MIXB: begin
        v_d[0]  = rotr64(v_q[0], ROT_V0);
        v_d[1]  = rotr64(v_q[1], ROT_V1);
        v_d[2]  = rotr64(v_q[2], ROT_V2);
        v_d[3]  = rotr64(t3, ROT_V3);
        state_d = ST_MIXC;
      end
      ST_MIXC: begin
        sig_d = rotr64(sig_q ^ ((v_q[0] & v_q[1]) | (v_q[2] ^ v_q[3])), ROT_SIG) + HASH_C1;
        if (xor_en_q) begin
          state_d = ST_POST;
        end else if (mix_left_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          mix_left_d = mix_left_q - 2'd1;
          state_d    = ST_MIXA;
        end
      end
      ST_POST: begin
        sig_d = rotr64(sig_q ^ ((v_q[0] + v_q[1]) ^ (v_q[2] - v_q[3])), ROT_POST);
        if (!fin_q) begin
          xor_en_d = 1'b0;
          state_d  = ST_IDLE;
        end else if (extra_q) begin
          // pad spilled over: one more, all-zero block
          extra_d = 1'b0;
          blk_d   = '0;
          state_d = ST_MIXA;
        end else begin
          xor_en_d   = 1'b0;
          mix_left_d = FINAL_MIXES_M1;
          state_d    = ST_MIXA;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.digest_word0 = v_q[0];
          out_d.digest_word1 = v_q[1];
          out_d.digest_word2 = v_q[2];
          out_d.digest_word3 = v_q[3];
          v_d                = '0;
          sig_d              = HASH_C1;
          fin_d              = 1'b0;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      v_q         <= '0;
      sig_q       <= HASH_C1;
      fin_q       <= 1'b0;
      extra_q     <= 1'b0;
      xor_en_q    <= 1'b0;
      mix_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      v_q         <= v_d;
      sig_q       <= sig_d;
      fin_q       <= fin_d;
      extra_q     <= extra_d;
      xor_en_q    <= xor_en_d;
      mix_left_q  <= mix_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

>>> rtl/byte_stream_hash_256.sv
// ----------------------------------------------------------------------------
// byte_stream_hash_256
// Streaming 256-bit hash over a byte stream, one message byte per beat.
// ----------------------------------------------------------------------------
// Takes one message byte per clock while the input is not stalled. Every 64th
// byte hands a block job to a two-entry queue. The mixing sequencer takes the
// job and then mixes it in the steps MIXA, MIXB, MIXC and POST. A steady byte
// stream never stalls. The input side stalls only when two jobs wait: either
// the digest output is held back, or finalize beats come closer together than
// the back end can drain. A finalize beat has the sequencer take the job and
// mix the padded block, then one more all-zero block if 56 or more bytes are
// pending, then run the four final mixes and load the digest register. The
// digest register lets the sequencer and the input side go on while a digest
// waits to be taken.
`default_nettype none

module byte_stream_hash_256 (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  bsh256_pkg::in_item_t  in_item_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output bsh256_pkg::out_item_t out_item_o,
  input  logic                  out_stall_i
);
  import bsh256_pkg::*;

  cmd_beat_t push, head;
  logic      q_full, pop;

  bsh256_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  bsh256_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  bsh256_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

>>> rtl/bsh256_checker.sv
// ----------------------------------------------------------------------------
// bsh256_checker
// Port-level checks of the hash block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_stream_hash_256_macros.svh"

module bsh256_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input bsh256_pkg::in_item_t  in_item_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input bsh256_pkg::out_item_t out_item_o,
  input logic                  out_stall_i
);
  import bsh256_pkg::*;

  // a held digest beat stays put
  `BSH_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))

  // the queue only fills up after a beat was taken
  `BSH_ASSERT(a_stall_rise, $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))

  // leaving reset with an empty queue and no pending digest
  `BSH_ASSERT_ALWAYS(a_reset_idle, $rose(rst_ni) |-> !in_stall_o && !out_valid_o)

endmodule

bind byte_stream_hash_256 bsh256_checker u_bsh256_checker (.*);

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams byte messages through byte_stream_hash_256 and checks each digest.
// ----------------------------------------------------------------------------
// A local model of the hash absorbs every accepted beat and queues the
// digest that each finalize beat must produce. Each digest taken from the
// output is checked word by word against the oldest queued one. Both sides
// insert random gaps, with stretches where neither side idles.
`timescale 1ns / 100ps

module testbench;
  import bsh256_pkg::*;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [63:0] SIG_INIT  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_K1    = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_K2    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_K3    = 64'h94D049BB133111EB;
  localparam int          MAX_GAP   = 6;
  localparam int          N_ITEMS   = 1500;
  localparam int          TAIL_CYC  = 40;
  localparam int          CYCLE_MAX = 300000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_item_o;
  logic      out_stall_i = 1'b0;

  byte_stream_hash_256 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hash state as the block should hold it
  logic [63:0] chain_q[4];
  logic [63:0] sig_q;
  logic [63:0] msg_bytes_q;
  logic [5:0]  fill_q;
  logic [7:0]  blk_buf[64];

  out_item_t   digest_q[$];
  int          errors      = 0;
  int          beats_sent  = 0;
  int          bytes_sent  = 0;
  int          digests_ok  = 0;
  int          n_overflow  = 0;
  int unsigned cycles      = 0;
  bit          quiet       = 1'b0;
  int          rx_wait     = 0;
  bit          rx_drawn    = 1'b0;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned r);
    return (x >> r) | (x << (64 - r));
  endfunction

  function automatic void hash_clear();
    for (int i = 0; i < 4; i++) chain_q[i] = '0;
    for (int i = 0; i < 64; i++) blk_buf[i] = '0;
    sig_q       = SIG_INIT;
    msg_bytes_q = '0;
    fill_q      = '0;
  endfunction

  function automatic void mix_round();
    chain_q[0] = chain_q[0] + (chain_q[1] ^ sig_q);
    chain_q[1] = chain_q[1] + (chain_q[2] ^ MIX_K1);
    chain_q[2] = chain_q[2] + (chain_q[3] ^ MIX_K2);
    // uses the updated word 0
    chain_q[3] = chain_q[3] + (chain_q[0] ^ MIX_K3);
    chain_q[0] = ror64(chain_q[0], 7);
    chain_q[1] = ror64(chain_q[1], 13);
    chain_q[2] = ror64(chain_q[2], 23);
    chain_q[3] = ror64(chain_q[3], 37);
    sig_q = sig_q ^ ((chain_q[0] & chain_q[1]) | (chain_q[2] ^ chain_q[3]));
    sig_q = ror64(sig_q, 17) + MIX_K1;
  endfunction

  function automatic void compress_block();
    logic [63:0] w;
    for (int k = 0; k < 4; k++) begin
      w = '0;
      for (int b = 0; b < 8; b++) w[8*b +: 8] = blk_buf[8*k + b];
      chain_q[k] = chain_q[k] ^ w;
    end
    mix_round();
    sig_q = sig_q ^ ((chain_q[0] + chain_q[1]) ^ (chain_q[2] - chain_q[3]));
    sig_q = ror64(sig_q, 31);
  endfunction

  function automatic void hash_byte(input logic [7:0] b);
    blk_buf[fill_q] = b;
    msg_bytes_q     = msg_bytes_q + 64'd1;
    fill_q          = fill_q + 6'd1;
    if (fill_q == 6'd0) compress_block();
  endfunction

  function automatic out_item_t hash_finish();
    out_item_t   d;
    int          pos;
    logic [63:0] bit_len;
    blk_buf[fill_q] = PAD_MARK;
    pos = int'(fill_q) + 1;
    // marker leaves no room for the length: spill into a fresh block
    if (pos > int'(LEN_OFFSET)) begin
      n_overflow++;
      while (pos < 64) begin
        blk_buf[pos] = '0;
        pos++;
      end
      compress_block();
      for (int i = 0; i < 64; i++) blk_buf[i] = '0;
      pos = 0;
    end
    while (pos < int'(LEN_OFFSET)) begin
      blk_buf[pos] = '0;
      pos++;
    end
    bit_len = msg_bytes_q << 3;
    for (int i = 0; i < 8; i++) blk_buf[int'(LEN_OFFSET) + i] = bit_len[8*i +: 8];
    compress_block();
    for (int i = 0; i < 4; i++) mix_round();
    d.digest_word0 = chain_q[0];
    d.digest_word1 = chain_q[1];
    d.digest_word2 = chain_q[2];
    d.digest_word3 = chain_q[3];
    hash_clear();
    return d;
  endfunction

  function automatic void check_word(input string name, input logic [63:0] exp_w,
                                     input logic [63:0] act_w);
    if (act_w !== exp_w) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_w, act_w);
      errors++;
    end
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input logic mode, input logic [7:0] value);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      in_item_i  <= in_item_t'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{mode: mode, byte_value: value};
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    if (mode == MODE_ABSORB) begin
      hash_byte(value);
      bytes_sent++;
    end else begin
      digest_q.push_back(hash_finish());
    end
    @(negedge clk_i);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(MODE_ABSORB, 8'($urandom));
    send_item(MODE_FINISH, 8'($urandom));
  endtask

  task automatic wait_digests();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
  endtask

  // digest output: random stall per beat, then check against the oldest digest
  always @(negedge clk_i) begin
    if (out_valid_o === 1'b1 && !rx_drawn) begin
      rx_wait  = quiet ? 0 : $urandom_range(0, MAX_GAP);
      rx_drawn = 1'b1;
    end
    if (rx_wait != 0) begin
      out_stall_i <= 1'b1;
      rx_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_d;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      rx_drawn = 1'b0;
      if (digest_q.size() == 0) begin
        $error("digest beat with nothing expected: %h", out_item_o);
        errors++;
      end else begin
        exp_d = digest_q.pop_front();
        check_word("digest_word0", exp_d.digest_word0, out_item_o.digest_word0);
        check_word("digest_word1", exp_d.digest_word1, out_item_o.digest_word1);
        check_word("digest_word2", exp_d.digest_word2, out_item_o.digest_word2);
        check_word("digest_word3", exp_d.digest_word3, out_item_o.digest_word3);
        digests_ok++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // empty message, ignored byte value at both extremes, two finalizes in a row
  task automatic test_empty_message();
    send_item(MODE_FINISH, 8'hFF);
    send_item(MODE_FINISH, 8'h00);
  endtask

  task automatic test_short_messages();
    send_item(MODE_ABSORB, 8'h00);
    send_item(MODE_FINISH, 8'h00);
    send_item(MODE_ABSORB, 8'hFF);
    send_item(MODE_FINISH, 8'hFF);
    send_item(MODE_ABSORB, 8'h80);
    send_item(MODE_ABSORB, 8'h55);
    send_item(MODE_ABSORB, 8'hAA);
    send_item(MODE_ABSORB, 8'h01);
    send_item(MODE_FINISH, 8'h5A);
  endtask

  // lengths around the length field and around full blocks
  task automatic test_pad_boundaries();
    int lens[9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
    foreach (lens[i]) send_message(lens[i]);
  endtask

  // bursts with no idling anywhere, so finalizes crowd the back end
  task automatic test_back_to_back();
    quiet = 1'b1;
    for (int i = 0; i < 6; i++) send_message($urandom_range(0, 2));
    send_message(60);
    send_item(MODE_FINISH, 8'($urandom));
    send_item(MODE_FINISH, 8'($urandom));
    quiet = 1'b0;
  endtask

  // sender holds off until every digest has come out
  task automatic test_drain_pause();
    send_message($urandom_range(1, 70));
    wait_digests();
    send_message(57);
    wait_digests();
  endtask

  task automatic test_random_messages();
    int len;
    while (beats_sent < N_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(55, 57);
        2: len = $urandom_range(63, 65);
        3: len = $urandom_range(119, 121);
        default: len = $urandom_range(0, 130);
      endcase
      send_message(len);
    end
    quiet = 1'b0;
  endtask

  initial begin
    hash_clear();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_message();
    test_short_messages();
    test_pad_boundaries();
    test_back_to_back();
    test_drain_pause();
    test_random_messages();

    wait_digests();
    repeat (TAIL_CYC) @(posedge clk_i);

    $display("sent %0d beats (%0d message bytes), checked %0d digests",
             beats_sent, bytes_sent, digests_ok);
    $display("%0d finalizes needed an extra padding block", n_overflow);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/bsh256_pkg.sv
rtl/bsh256_front.sv
rtl/bsh256_queue.sv
rtl/bsh256_back.sv
rtl/byte_stream_hash_256.sv
rtl/bsh256_checker.sv
dv/testbench.sv
